// ===== hw/rtl/tpa3_pkg.sv =====
// tpa3_pkg: shared widths for the triangle perimeter and area block
// no dependencies
package tpa3_pkg;
  localparam int unsigned PERIM_W = 19;
  localparam int unsigned AREA_W = 33;
  localparam int unsigned IN_BYTES = 18;
  localparam int unsigned OUT_BYTES = 7;
endpackage

// ===== hw/rtl/tpa3_sqrt_cell.sv =====
// tpa3_sqrt_cell: one restoring square root step of a pipelined root chain
// depends on nothing; payload travels beside the root state
module tpa3_sqrt_cell #(
  parameter int RAD_W = 32,
  parameter int ROOT_W = 16,
  parameter int PASS_W = 1,
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rem_i,
  input  logic [ROOT_W-1:0] root_i,
  input  logic [PASS_W-1:0] pass_i,
  output logic [RAD_W-1:0]  rem_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [PASS_W-1:0] pass_o
);
  localparam int BIT = ROOT_W - 1 - STEP;

  logic [RAD_W+1:0]  trial;
  logic [RAD_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [PASS_W-1:0] pass_r;
  logic [RAD_W+1:0]  cand_sq;
  logic [ROOT_W:0]   cand;

  // (root + 2^b)^2 - root^2 = 2^(2b) + root*2^(b+1)
  always_comb begin
    cand = {1'b0, root_i};
    cand_sq = ({{(RAD_W+2-ROOT_W-1){1'b0}}, cand} << (BIT + 1))
            + ({{(RAD_W+1){1'b0}}, 1'b1} << (2 * BIT));
    trial = {2'b00, rem_i} - cand_sq;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pass_r <= pass_i;
      if (!trial[RAD_W+1]) begin
        rem_r <= trial[RAD_W-1:0];
        root_r <= root_i | (ROOT_W'(1) << BIT);
      end else begin
        rem_r <= rem_i;
        root_r <= root_i;
      end
    end
  end

  assign rem_o = rem_r;
  assign root_o = root_r;
  assign pass_o = pass_r;
endmodule

// ===== hw/rtl/tpa3_sqrt_chain.sv =====
// tpa3_sqrt_chain: row of root cells, one result bit per cell per cycle while en is high
// depends on tpa3_sqrt_cell
module tpa3_sqrt_chain #(
  parameter int RAD_W = 32,
  parameter int ROOT_W = 16,
  parameter int PASS_W = 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rad_i,
  input  logic [PASS_W-1:0] pass_i,
  output logic [ROOT_W-1:0] root_o,
  output logic [PASS_W-1:0] pass_o
);
  logic [RAD_W-1:0]  rem_w [ROOT_W+1];
  logic [ROOT_W-1:0] root_w [ROOT_W+1];
  logic [PASS_W-1:0] pass_w [ROOT_W+1];

  assign rem_w[0] = rad_i;
  assign root_w[0] = '0;
  assign pass_w[0] = pass_i;

  for (genvar g = 0; g < ROOT_W; g++) begin : g_cell
    tpa3_sqrt_cell #(
      .RAD_W(RAD_W), .ROOT_W(ROOT_W), .PASS_W(PASS_W), .STEP(g)
    ) u_cell (
      .clk(clk), .en(en),
      .rem_i(rem_w[g]), .root_i(root_w[g]), .pass_i(pass_w[g]),
      .rem_o(rem_w[g+1]), .root_o(root_w[g+1]), .pass_o(pass_w[g+1])
    );
  end

  assign root_o = root_w[ROOT_W];
  assign pass_o = pass_w[ROOT_W];
endmodule

// ===== hw/rtl/triangle_perimeter_area_3d.sv =====
// triangle_perimeter_area_3d: perimeter and heron area of a 3d triangle
// depends on tpa3_pkg and tpa3_sqrt_chain
//
// channel | dir | payload
// in_     | in  | a_x a_y a_z b_x b_y b_z c_x c_y c_z
// out_    | out | valid_res perimeter area
//
// one item per cycle while the output is not held; the path runs through the differences,
// squares and sums, side root chains, heron stages, area root chain and output register
// the whole pipe advances together; a held output stalls every stage
// reset clears only the valid bits of the stages
module triangle_perimeter_area_3d #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // a_x a_y a_z b_x b_y b_z c_x c_y c_z from low bits, zero padded
  input  logic [((9*COORD_BITS+7)/8)*8-1:0] in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // valid_res perimeter area from low bits, zero padded
  output logic [tpa3_pkg::OUT_BYTES*8-1:0] out_tdata
);
  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;          // coordinate difference magnitude
  localparam int SQW = 2 * DW + 2;     // sum of three squares
  localparam int SW = DW + 1;          // side root width
  localparam int PW = SW + 2;          // perimeter width
  localparam int XW = 4 * PW;          // heron product
  localparam int RW = 2 * PW;          // root of the product
  localparam int PASS1 = 1;
  localparam int LAT1 = 3 + SW;
  localparam int LAT2 = 4 + RW;
  localparam int LAT = LAT1 + LAT2;

  logic adv;
  logic [LAT-1:0] vld_r;
  logic out_vld_r;

  assign adv = !out_vld_r || out_tready;
  assign in_tready = adv;
  assign out_tvalid = out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
      out_vld_r <= vld_r[LAT-1];
    end
  end

  // stage 1: differences
  logic signed [CB-1:0] crd [9];
  logic [DW-1:0] dif_r [9];
  for (genvar g = 0; g < 9; g++) begin : g_crd
    assign crd[g] = in_tdata[g*CB +: CB];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        dif_r[k] <= DW'(($signed({crd[k][CB-1], crd[k]}) >= $signed({crd[k+3][CB-1], crd[k+3]}))
          ? {crd[k][CB-1], crd[k]} - {crd[k+3][CB-1], crd[k+3]}
          : {crd[k+3][CB-1], crd[k+3]} - {crd[k][CB-1], crd[k]});
        dif_r[k+3] <= DW'(($signed({crd[k][CB-1], crd[k]}) >= $signed({crd[k+6][CB-1], crd[k+6]}))
          ? {crd[k][CB-1], crd[k]} - {crd[k+6][CB-1], crd[k+6]}
          : {crd[k+6][CB-1], crd[k+6]} - {crd[k][CB-1], crd[k]});
        dif_r[k+6] <= DW'(($signed({crd[k+3][CB-1], crd[k+3]}) >= $signed({crd[k+6][CB-1], crd[k+6]}))
          ? {crd[k+3][CB-1], crd[k+3]} - {crd[k+6][CB-1], crd[k+6]}
          : {crd[k+6][CB-1], crd[k+6]} - {crd[k+3][CB-1], crd[k+3]});
      end
    end
  end

  // stage 2: squares, stage 3: sums
  logic [2*DW-1:0] sq_r [9];
  logic [SQW-1:0] ssq_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 9; k++) sq_r[k] <= dif_r[k] * dif_r[k];
      for (int s = 0; s < 3; s++) begin
        ssq_r[s] <= SQW'(sq_r[3*s]) + SQW'(sq_r[3*s+1]) + SQW'(sq_r[3*s+2]);
      end
    end
  end

  logic [SW-1:0] side [3];
  logic [PASS1-1:0] unused_pass [3];
  for (genvar g = 0; g < 3; g++) begin : g_side
    tpa3_sqrt_chain #(.RAD_W(SQW), .ROOT_W(SW), .PASS_W(PASS1)) u_root (
      .clk(clk), .en(adv), .rad_i(ssq_r[g]), .pass_i(1'b0),
      .root_o(side[g]), .pass_o(unused_pass[g])
    );
  end

  // heron factors
  logic [PW-1:0] per_r, f1_r, f2_r, f3_r;
  logic ok_r;
  logic [PW-1:0] sa, sb, sc;
  always_comb begin
    sa = PW'(side[0]);
    sb = PW'(side[1]);
    sc = PW'(side[2]);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      per_r <= sa + sb + sc;
      f1_r <= sb + sc - sa;
      f2_r <= sa + sc - sb;
      f3_r <= sa + sb - sc;
      ok_r <= (sa != '0) && (sb != '0) && (sc != '0) && (sa + sc > sb)
              && (sa + sb > sc) && (sb + sc > sa);
    end
  end

  // two products, then the wide product in two partial halves
  logic [2*PW-1:0] m1_r, m2_r;
  logic [PW-1:0] per2_r, per3_r;
  logic ok2_r, ok3_r, ok4_r;
  logic [XW-1:0] plo_r, phi_r, x_r;
  logic [PW-1:0] per4_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r <= per_r * f1_r;
      m2_r <= f2_r * f3_r;
      per2_r <= per_r;
      ok2_r <= ok_r;
      plo_r <= XW'(m1_r * m2_r[PW-1:0]);
      phi_r <= XW'(m1_r * m2_r[2*PW-1:PW]) << PW;
      per3_r <= per2_r;
      ok3_r <= ok2_r;
      x_r <= plo_r + phi_r;
      per4_r <= per3_r;
      ok4_r <= ok3_r;
    end
  end

  logic [RW-1:0] aroot;
  logic [PW:0] pass_o;
  tpa3_sqrt_chain #(.RAD_W(XW), .ROOT_W(RW), .PASS_W(PW+1)) u_area (
    .clk(clk), .en(adv), .rad_i(ok4_r ? x_r : '0), .pass_i({ok4_r, per4_r}),
    .root_o(aroot), .pass_o(pass_o)
  );

  logic [tpa3_pkg::AREA_W-1:0] area;
  logic [tpa3_pkg::PERIM_W-1:0] perim;
  logic [RW+tpa3_pkg::AREA_W-1:0] area_ext;
  logic [PW+tpa3_pkg::PERIM_W-1:0] per_ext;
  assign area_ext = {{tpa3_pkg::AREA_W{1'b0}}, aroot} >> 2;
  assign per_ext = {{tpa3_pkg::PERIM_W{1'b0}}, pass_o[PW-1:0]};
  assign area = pass_o[PW] ? area_ext[tpa3_pkg::AREA_W-1:0] : '0;
  assign perim = pass_o[PW] ? per_ext[tpa3_pkg::PERIM_W-1:0] : '0;

  logic [tpa3_pkg::OUT_BYTES*8-1:0] out_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= {3'b000, area, perim, pass_o[PW]};
    end
  end
  assign out_tdata = out_r;
endmodule

// ===== hw/rtl/tpa3_checker.sv =====
// tpa3_checker: port level checks on the triangle block
// binds to triangle_perimeter_area_3d
module tpa3_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [55:0] out_tdata
);
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready) else $error("ready while held");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata)) else $error("data moved");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[52:1] == '0)) else $error("invalid nonzero");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid) else $error("reset");
endmodule

bind triangle_perimeter_area_3d tpa3_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata)
);

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking bench for triangle_perimeter_area_3d
// drives random and corner-case point triples, checks against an internal predictor
// depends on tpa3_pkg and the block rtl
`timescale 1ns / 1ps

class tri_scoreboard;
  logic [tpa3_pkg::OUT_BYTES*8-1:0] pending[$];
  int errors;

  function automatic logic [63:0] root_floor(logic [127:0] v);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      c = r | (64'd1 << k);
      if ({64'd0, c} * {64'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [63:0] side(logic signed [15:0] p[3], logic signed [15:0] q[3]);
    logic [127:0] acc;
    longint d;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      d = longint'(p[i]) - longint'(q[i]);
      if (d < 0) d = -d;
      acc += 128'(d) * 128'(d);
    end
    return root_floor(acc);
  endfunction

  function void note_input(logic [143:0] pts);
    logic signed [15:0] a[3], b[3], c[3];
    logic [63:0] sab, sac, sbc, per, ar;
    logic [127:0] x;
    logic [tpa3_pkg::OUT_BYTES*8-1:0] res;
    for (int i = 0; i < 3; i++) begin
      a[i] = pts[16*i +: 16];
      b[i] = pts[16*(i+3) +: 16];
      c[i] = pts[16*(i+6) +: 16];
    end
    sab = side(a, b);
    sac = side(a, c);
    sbc = side(b, c);
    res = '0;
    if (sab > 0 && sac > 0 && sbc > 0 && sab + sbc > sac && sab + sac > sbc
        && sac + sbc > sab) begin
      per = sab + sac + sbc;
      x = 128'(per) * 128'(per - 2*sab) * 128'(per - 2*sac) * 128'(per - 2*sbc);
      ar = root_floor(x) >> 2;
      res[0] = 1'b1;
      res[1 +: tpa3_pkg::PERIM_W] = per[tpa3_pkg::PERIM_W-1:0];
      res[1+tpa3_pkg::PERIM_W +: tpa3_pkg::AREA_W] = ar[tpa3_pkg::AREA_W-1:0];
    end
    pending.push_back(res);
  endfunction

  function void check_result(logic [tpa3_pkg::OUT_BYTES*8-1:0] got);
    logic [tpa3_pkg::OUT_BYTES*8-1:0] exp;
    if (pending.size() == 0) begin
      $display("%0t: unexpected item %h", $time, got);
      errors++;
      return;
    end
    exp = pending.pop_front();
    if (got[0] !== exp[0]) begin
      $display("%0t: valid_res exp %0d got %0d", $time, exp[0], got[0]);
      errors++;
    end
    if (got[1 +: tpa3_pkg::PERIM_W] !== exp[1 +: tpa3_pkg::PERIM_W]) begin
      $display("%0t: perimeter exp %0d got %0d", $time, exp[1 +: tpa3_pkg::PERIM_W],
               got[1 +: tpa3_pkg::PERIM_W]);
      errors++;
    end
    if (got[1+tpa3_pkg::PERIM_W +: tpa3_pkg::AREA_W]
        !== exp[1+tpa3_pkg::PERIM_W +: tpa3_pkg::AREA_W]) begin
      $display("%0t: area exp %0d got %0d", $time, exp[1+tpa3_pkg::PERIM_W +: tpa3_pkg::AREA_W],
               got[1+tpa3_pkg::PERIM_W +: tpa3_pkg::AREA_W]);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int LATENCY = 3 + 18 + 4 + 40 + 1;
  localparam int WATCH_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [143:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [tpa3_pkg::OUT_BYTES*8-1:0] out_tdata;

  tri_scoreboard board = new();
  logic quiet_phase = 1'b0;
  int idle_cycles = 0;

  triangle_perimeter_area_3d i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) board.note_input(in_tdata);
      if (out_tvalid && out_tready) board.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
      out_tready <= quiet_phase || $urandom_range(99) >= 27;
    end
  end

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(15)) - 8);
      4: return 16'(int'($urandom_range(400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send(logic [143:0] pts);
    while (!quiet_phase && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= pts;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [143:0] pack(int v[9]);
    logic [143:0] p;
    for (int i = 0; i < 9; i++) p[16*i +: 16] = 16'(v[i]);
    return p;
  endfunction

  function automatic logic [143:0] random_tri();
    logic [143:0] p;
    int pick;
    for (int i = 0; i < 9; i++) p[16*i +: 16] = pick_coord();
    pick = $urandom_range(19);
    if (pick == 0) p[48 +: 48] = p[0 +: 48];
    else if (pick == 1) begin
      for (int i = 0; i < 3; i++)
        p[16*(i+6) +: 16] = 16'(2*$signed(p[16*(i+3) +: 16]) - $signed(p[16*i +: 16]));
    end
    return p;
  endfunction

  initial begin
    logic [143:0] p;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send(pack('{0, 0, 0, 3, 0, 0, 0, 4, 0}));
    send(pack('{0, 0, 0, 0, 0, 0, 5, 5, 5}));
    send(pack('{1, 1, 1, 1, 1, 1, 1, 1, 1}));
    send(pack('{0, 0, 0, 1, 1, 1, 2, 2, 2}));
    send(pack('{0, 0, 0, 10, 0, 0, 20, 1, 0}));
    send(pack('{0, 0, 0, 1, 0, 0, 0, 1, 0}));
    send(pack('{-32768, -32768, -32768, 32767, 32767, 32767, -32768, 32767, -32768}));
    send(pack('{32767, -32768, 0, -32768, 32767, 0, 0, 0, 32767}));
    send(pack('{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768}));
    send(pack('{-1, -1, -1, 0, 0, 0, 1, -1, 0}));
    send(pack('{0, 0, 0, 32767, 32767, 32767, -32768, -32768, -32768}));
    send(pack('{5, -7, 9, -12, 3, 100, 40, 40, -40}));
    for (int n = 0; n < 1300; n++) begin
      quiet_phase = (n >= 500 && n < 700);
      send(random_tri());
    end
    in_tvalid <= 1'b0;
    quiet_phase = 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/tpa3_pkg.sv
hw/rtl/tpa3_sqrt_cell.sv
hw/rtl/tpa3_sqrt_chain.sv
hw/rtl/triangle_perimeter_area_3d.sv
hw/rtl/tpa3_checker.sv
tb/sv/tb_top.sv
